// ===== rtl/core/ssi_pkg.sv =====
// Shared types and constants for the sorted set insertion block.
package ssi_pkg;

  // Key width of one stored entry.
  localparam int unsigned KEY_W = 32;

  // Width of the reported entry count.
  localparam int unsigned CNT_OUT_W = 5;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_RSVD      = 2'd3
  } ssi_status_t;

  // Control strobes broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;   // register the compare flags against the held key
    logic ins_en;   // perform the insertion shift
  } ssi_cell_ctrl_t;

endpackage

// ===== rtl/core/ssi_cell.sv =====
// One slot of the sorted chain: holds a key and its compare flags.
module ssi_cell
  import ssi_pkg::*;
(
  input  logic                   clk,
  input  ssi_cell_ctrl_t         ctrl,
  input  logic                   slot_valid,   // slot lies below the fill count
  input  logic signed [KEY_W-1:0] new_key,
  input  logic                   prev_lt,      // left neighbour holds a smaller key
  input  logic signed [KEY_W-1:0] prev_key,    // left neighbour's key
  output logic signed [KEY_W-1:0] key_q,
  output logic                   lt_q,
  output logic                   eq_q
);

  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic                    lt_r, lt_nxt;
  logic                    eq_r, eq_nxt;

  // Compare phase: flag a valid slot whose key is smaller than or equal to the new key.
  always_comb begin
    lt_nxt = lt_r;
    eq_nxt = eq_r;
    if (ctrl.cmp_en) begin
      lt_nxt = slot_valid && (key_r < new_key);
      eq_nxt = slot_valid && (key_r == new_key);
    end
  end

  // Insert phase: smaller keys stay, the boundary slot takes the new key,
  // everything above moves up by one slot.
  always_comb begin
    key_nxt = key_r;
    if (ctrl.ins_en && !lt_r) begin
      if (prev_lt) begin
        key_nxt = new_key;
      end else begin
        key_nxt = prev_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    lt_r  <= lt_nxt;
    eq_r  <= eq_nxt;
  end

  assign key_q = key_r;
  assign lt_q  = lt_r;
  assign eq_q  = eq_r;

endmodule

// ===== rtl/core/sorted_set_insert_no_duplicates.sv =====
// Top level of the sorted set: sequencer, chain of key cells and result register.
//
//   Channel | Ports                                          | Direction
//   input   | in_valid, in_stall, in_key                     | beat in
//   result  | out_valid, out_stall, out_status,              | beat out
//           | out_largest_key, out_set_empty, out_entry_count|
//
// Each key goes through capture, a parallel compare in every cell,
// and the shift that moves larger keys up one cell.
// The next key is taken only once the shift is done.
// A stalled result holds the shift phase until the result register frees.
// Reset empties the set by clearing the fill count; stored keys are not cleared.
module sorted_set_insert_no_duplicates
  import ssi_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic signed [KEY_W-1:0] out_largest_key,
  output logic                    out_set_empty,
  output logic [CNT_OUT_W-1:0]    out_entry_count
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] largest_r, largest_nxt;

  logic                    out_valid_r;
  ssi_status_t             out_status_r, status_nxt;
  logic signed [KEY_W-1:0] out_largest_r;
  logic                    out_empty_r;
  logic [CNT_W-1:0]        out_count_r;

  ssi_cell_ctrl_t          ctrl;
  logic [CAPACITY-1:0]     slot_valid;
  logic [CAPACITY-1:0]     lt_v;
  logic [CAPACITY-1:0]     eq_v;
  logic signed [KEY_W-1:0] cell_key [CAPACITY];

  logic                    dup_hit;
  logic                    is_full;
  logic                    all_lt;
  logic                    out_free;
  logic                    do_insert;
  logic                    finish;
  logic                    in_accept;
  logic [31:0]             out_count_ext;

  // Handshake terms.
  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign finish    = (state_r == S_UPD) && out_free;

  // Search results gathered from the registered cell flags.
  assign dup_hit   = |eq_v;
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign all_lt    = &(lt_v | ~slot_valid);
  assign do_insert = !dup_hit && !is_full;

  assign ctrl.cmp_en = (state_r == S_CMP);
  assign ctrl.ins_en = finish && do_insert;

  // Chain of cells; each slot is valid below the fill count.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign slot_valid[i] = (CNT_W'(i) < count_r);
    if (i == 0) begin : g_head
      ssi_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .slot_valid (slot_valid[i]),
        .new_key    (key_r),
        .prev_lt    (1'b1),
        .prev_key   (key_r),
        .key_q      (cell_key[i]),
        .lt_q       (lt_v[i]),
        .eq_q       (eq_v[i])
      );
    end else begin : g_body
      ssi_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .slot_valid (slot_valid[i]),
        .new_key    (key_r),
        .prev_lt    (lt_v[i-1]),
        .prev_key   (cell_key[i-1]),
        .key_q      (cell_key[i]),
        .lt_q       (lt_v[i]),
        .eq_q       (eq_v[i])
      );
    end
  end

  // Next count, largest key and status for the step being finished.
  always_comb begin
    count_nxt   = count_r;
    largest_nxt = largest_r;
    if (dup_hit) begin
      status_nxt = ST_DUPLICATE;
    end else if (is_full) begin
      status_nxt = ST_FULL;
    end else begin
      status_nxt = ST_INSERTED;
      count_nxt  = count_r + CNT_W'(1);
      if (all_lt) begin
        largest_nxt = key_r;
      end
    end
  end

  // Sequencer, set bookkeeping, payload and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            state_r <= S_CMP;
            key_r   <= in_key;
          end
        end
        S_CMP: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (out_free) begin
            state_r       <= S_IDLE;
            count_r       <= count_nxt;
            largest_r     <= largest_nxt;
            out_status_r  <= status_nxt;
            out_largest_r <= (count_nxt == '0) ? '0 : largest_nxt;
            out_empty_r   <= (count_nxt == '0);
            out_count_r   <= count_nxt;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_count_ext   = 32'(out_count_r);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_largest_key = out_largest_r;
  assign out_set_empty   = out_empty_r;
  assign out_entry_count = out_count_ext[CNT_OUT_W-1:0];

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // An insertion grows the set by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins_en |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insertion did not grow the set by one");

  // A duplicate or full result leaves the count unchanged.
  a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && !do_insert) |=> $stable(count_r))
    else $error("count changed without an insertion");

  // The reserved status code is never reported.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_status_r != ST_RSVD)
    else $error("reserved status reported");

endmodule

// ===== tb/tb_sorted_set_insert_no_duplicates.sv =====
// Self-checking testbench for the sorted set insertion block.
module tb_sorted_set_insert_no_duplicates
  import ssi_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SET_CAP       = 16;
  localparam int unsigned RANDOM_BEATS  = 1750;
  localparam int unsigned PHASE_LEN     = 160;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

  // One result beat as the set should report it.
  typedef struct packed {
    ssi_status_t                status;
    logic signed [KEY_W-1:0]    largest;
    logic                       empty;
    logic [CNT_OUT_W-1:0]       count;
  } insert_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [KEY_W-1:0] in_key;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              out_status;
  logic signed [KEY_W-1:0] out_largest_key;
  logic                    out_set_empty;
  logic [CNT_OUT_W-1:0]    out_entry_count;

  // Shadow copy of the stored keys, ascending.
  logic signed [KEY_W-1:0] shadow_keys [SET_CAP];
  int unsigned             shadow_count;

  logic signed [KEY_W-1:0] pending_keys [$];
  insert_result_t          awaited_results [$];

  int unsigned beats_sent;
  int unsigned results_seen;
  int unsigned mismatch_count;
  int unsigned directed_beats;
  int unsigned n_inserted;
  int unsigned n_duplicate;
  int unsigned n_full;

  // Idle and stall percentages, one entry per traffic phase.
  int unsigned send_idle_pct [4] = '{0, 59, 0, 23};
  int unsigned recv_stall_pct [4] = '{0, 0, 59, 23};

  insert_result_t want;

  sorted_set_insert_no_duplicates #(
    .CAPACITY(SET_CAP)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_key(in_key),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_largest_key(out_largest_key),
    .out_set_empty(out_set_empty),
    .out_entry_count(out_entry_count)
  );

  // Clock with a 4 ns period.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Traffic phase rotates as beats go in, so gaps land on every stage of the work.
  function automatic int unsigned traffic_phase();
    return (beats_sent / PHASE_LEN) % 4;
  endfunction

  // Offer one key to the shadow set and return what the block should report.
  function automatic insert_result_t predict_insert(input logic signed [KEY_W-1:0] key);
    insert_result_t res;
    int unsigned    pos;
    int unsigned    i;
    pos = 0;
    while (pos < shadow_count && shadow_keys[pos] < key) pos++;
    if (pos < shadow_count && shadow_keys[pos] == key) begin
      res.status = ST_DUPLICATE;
    end else if (shadow_count >= SET_CAP) begin
      res.status = ST_FULL;
    end else begin
      for (i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
      shadow_keys[pos] = key;
      shadow_count++;
      res.status = ST_INSERTED;
    end
    res.largest = (shadow_count != 0) ? shadow_keys[shadow_count-1] : '0;
    res.empty   = (shadow_count == 0);
    res.count   = CNT_OUT_W'(shadow_count);
    return res;
  endfunction

  // Count a mismatch and describe it while under the report limit.
  task automatic note_mismatch(input string field, input logic [KEY_W-1:0] exp_val,
                               input logic [KEY_W-1:0] got_val);
    if (mismatch_count < REPORT_LIMIT) begin
      $display("[%0t] result %0d: %s expected %h, got %h",
               $realtime, results_seen, field, exp_val, got_val);
    end
    mismatch_count++;
  endtask

  // Input driver: predict each accepted beat, then present the next key or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_key     <= '0;
      beats_sent <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_results.push_back(predict_insert(in_key));
        beats_sent <= beats_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_keys.size() > 0 &&
            $urandom_range(99) >= send_idle_pct[traffic_phase()]) begin
          in_key   <= pending_keys.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted beat with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          note_mismatch("unexpected result, status", KEY_W'(0), KEY_W'(out_status));
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status)
            note_mismatch("status", KEY_W'(want.status), KEY_W'(out_status));
          if (out_largest_key !== want.largest)
            note_mismatch("largest_key", want.largest, out_largest_key);
          if (out_set_empty !== want.empty)
            note_mismatch("set_empty", KEY_W'(want.empty), KEY_W'(out_set_empty));
          if (out_entry_count !== want.count)
            note_mismatch("entry_count", KEY_W'(want.count), KEY_W'(out_entry_count));
          case (want.status)
            ST_INSERTED:  n_inserted++;
            ST_DUPLICATE: n_duplicate++;
            default:      n_full++;
          endcase
        end
        results_seen++;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct[traffic_phase()]);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic signed [KEY_W-1:0] stored_pool [$];
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] pick;
    int unsigned             sel;
    int unsigned             n;

    rst_n = 1'b0;

    // Directed: first key into an empty set, a repeat, both extremes at the ends,
    // and repeats of the extremes.
    pending_keys = '{32'sd0, 32'sd0, KEY_MIN, KEY_MAX, -32'sd1, 32'sd1, KEY_MIN, KEY_MAX};
    stored_pool  = '{32'sd0, KEY_MIN, KEY_MAX, -32'sd1, 32'sd1};
    // Fill the remaining slots with keys that land at random places.
    for (n = 0; n < SET_CAP - 5; n++) begin
      key = $urandom;
      pending_keys.push_back(key);
      stored_pool.push_back(key);
    end
    // With the store full: new keys are refused, repeats still report duplicate.
    pending_keys.push_back(KEY_MAX - 1);
    pending_keys.push_back(KEY_MIN + 1);
    pending_keys.push_back(32'sd1);
    pending_keys.push_back(KEY_MAX);
    directed_beats = pending_keys.size();

    // Random part: repeats of stored keys, their neighbours, extremes and free keys.
    for (n = 0; n < RANDOM_BEATS; n++) begin
      sel  = $urandom_range(99);
      pick = stored_pool[$urandom_range(stored_pool.size() - 1)];
      if (sel < 45) begin
        key = pick;
      end else if (sel < 70) begin
        key = $urandom_range(1) ? pick + 1 : pick - 1;
      end else if (sel < 80) begin
        case ($urandom_range(3))
          0:       key = KEY_MIN;
          1:       key = KEY_MAX;
          2:       key = '0;
          default: key = -32'sd1;
        endcase
      end else begin
        key = $urandom;
      end
      pending_keys.push_back(key);
    end

    // Reset held low from the start, released on a rising edge.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every beat to go in and every prediction to be met.
    while (pending_keys.size() > 0 || in_valid || awaited_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d keys (%0d directed); checked %0d results.",
             beats_sent, directed_beats, results_seen);
    $display("Outcomes: %0d inserted, %0d duplicate, %0d refused with the set full.",
             n_inserted, n_duplicate, n_full);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
